>>> sv/pcpt_pkg.sv
// Shared types and constants for the pulse coded packet transmitter.
`default_nettype none

package pcpt_pkg;

   // Defaults for the top-level parameters
   localparam int FRAME_BITS_DEF  = 7;
   localparam int TIMER_WIDTH_DEF = 24;
   // Widest frame the frame builder supports
   localparam int FRAME_MAX       = 8;

   // Register file layout
   localparam int REG_W = 24;
   localparam int IDX_W = 3;

   localparam logic [IDX_W-1:0] REG_SHORT_PULSE = 3'd0;
   localparam logic [IDX_W-1:0] REG_LONG_PULSE  = 3'd1;
   localparam logic [IDX_W-1:0] REG_ZERO_GAP    = 3'd2;
   localparam logic [IDX_W-1:0] REG_ONE_GAP     = 3'd3;
   localparam logic [IDX_W-1:0] REG_COOLDOWN    = 3'd4;

   localparam logic [REG_W-1:0] SHORT_PULSE_RST = 24'd1200;
   localparam logic [REG_W-1:0] LONG_PULSE_RST  = 24'd3200;
   localparam logic [REG_W-1:0] ZERO_GAP_RST    = 24'd100000;
   localparam logic [REG_W-1:0] ONE_GAP_RST     = 24'd200000;
   localparam logic [REG_W-1:0] COOLDOWN_RST    = 24'd1500000;

   // Request status codes
   localparam logic [1:0] ST_NONE     = 2'd0;
   localparam logic [1:0] ST_ACCEPTED = 2'd1;
   localparam logic [1:0] ST_COOLDOWN = 2'd2;
   localparam logic [1:0] ST_BUSY     = 2'd3;

   // Input kind carried in tuser
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_SEND = 1'b1;

   typedef struct packed {
      logic [REG_W-1:0] short_pulse_ticks;
      logic [REG_W-1:0] long_pulse_ticks;
      logic [REG_W-1:0] zero_gap_ticks;
      logic [REG_W-1:0] one_gap_ticks;
      logic [REG_W-1:0] cooldown_ticks;
   } cfg_type;

   typedef struct packed {
      logic       trigger_level;
      logic       busy_res;
      logic [1:0] request_status;
      logic       frame_done;
   } result_type;

endpackage

`default_nettype wire

>>> sv/pcpt_csr.sv
// Configuration register file for the transmitter timing values.
`default_nettype none

module pcpt_csr (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire  [pcpt_pkg::IDX_W-1:0] csr_index,
   input  wire  [pcpt_pkg::REG_W-1:0] csr_wdata,
   output pcpt_pkg::cfg_type          cfg
);
   import pcpt_pkg::*;

   cfg_type cfg_ff;
   logic    wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;
   assign cfg       = cfg_ff;

   // Register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_pulse_ticks <= SHORT_PULSE_RST;
         cfg_ff.long_pulse_ticks  <= LONG_PULSE_RST;
         cfg_ff.zero_gap_ticks    <= ZERO_GAP_RST;
         cfg_ff.one_gap_ticks     <= ONE_GAP_RST;
         cfg_ff.cooldown_ticks    <= COOLDOWN_RST;
      end else if (wr) begin
         case (csr_index)
            REG_SHORT_PULSE: cfg_ff.short_pulse_ticks <= csr_wdata;
            REG_LONG_PULSE:  cfg_ff.long_pulse_ticks  <= csr_wdata;
            REG_ZERO_GAP:    cfg_ff.zero_gap_ticks    <= csr_wdata;
            REG_ONE_GAP:     cfg_ff.one_gap_ticks     <= csr_wdata;
            REG_COOLDOWN:    cfg_ff.cooldown_ticks    <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> sv/pcpt_engine.sv
// Sequencer: phase timers, frame shifter and cooldown; one request per acc cycle.
`default_nettype none

module pcpt_engine #(
   parameter int FRAME_BITS  = pcpt_pkg::FRAME_BITS_DEF,
   parameter int TIMER_WIDTH = pcpt_pkg::TIMER_WIDTH_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  acc,
   input  wire                  func,
   input  wire  [2:0]           sym_code,
   input  wire  [1:0]           intensity,
   input  pcpt_pkg::cfg_type    cfg,
   output pcpt_pkg::result_type res
);
   import pcpt_pkg::*;

   localparam int BL_W = $clog2(FRAME_BITS + 1);

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_Z_P1 = 3'd1,
      PH_Z_G1 = 3'd2,
      PH_Z_P2 = 3'd3,
      PH_Z_G2 = 3'd4,
      PH_O_P  = 3'd5,
      PH_O_G  = 3'd6
   } phase_type;

   phase_type              phase_ff,    phase_in;
   logic [FRAME_BITS-1:0]  shift_ff,    shift_in;
   logic [BL_W-1:0]        bits_ff,     bits_in;
   logic [TIMER_WIDTH-1:0] timer_ff,    timer_in;
   logic [TIMER_WIDTH-1:0] cool_ff,     cool_in;

   logic [FRAME_MAX-1:0]   frame_word;
   logic [FRAME_BITS-1:0]  next_shift;
   logic [BL_W-1:0]        bits_dec;
   logic [1:0]             status;
   logic                   done;

   // Zero duration acts as one tick
   function automatic logic [TIMER_WIDTH-1:0] dur(input logic [REG_W-1:0] r);
      logic [TIMER_WIDTH-1:0] v;
      v = TIMER_WIDTH'(r);
      return (v == '0) ? TIMER_WIDTH'(1) : v;
   endfunction

   function automatic logic [TIMER_WIDTH-1:0] phase_len(input phase_type ph,
                                                        input cfg_type c);
      logic [TIMER_WIDTH-1:0] t;
      case (ph)
         PH_Z_P1, PH_Z_P2: t = dur(c.short_pulse_ticks);
         PH_Z_G1, PH_Z_G2: t = dur(c.zero_gap_ticks);
         PH_O_P:           t = dur(c.long_pulse_ticks);
         PH_O_G:           t = dur(c.one_gap_ticks);
         default:          t = '0;
      endcase
      return t;
   endfunction

   // Start, code, intensity, stop; truncated to the frame width
   assign frame_word = (FRAME_MAX'(1) << (FRAME_BITS - 1))
                     | {{(FRAME_MAX-6){1'b0}}, sym_code, intensity, 1'b1};
   assign next_shift = shift_ff << 1;
   assign bits_dec   = (bits_ff != '0) ? bits_ff - BL_W'(1) : bits_ff;

   // Next state for one request
   always_comb begin
      phase_in = phase_ff;
      shift_in = shift_ff;
      bits_in  = bits_ff;
      timer_in = timer_ff;
      cool_in  = cool_ff;
      status   = ST_NONE;
      done     = 1'b0;
      if (func == FUNC_SEND) begin
         if (phase_ff != PH_IDLE) begin
            status = ST_BUSY;
         end else if (cool_ff != '0) begin
            status = ST_COOLDOWN;
         end else begin
            status   = ST_ACCEPTED;
            shift_in = frame_word[FRAME_BITS-1:0];
            bits_in  = BL_W'(FRAME_BITS);
            cool_in  = TIMER_WIDTH'(cfg.cooldown_ticks);
            phase_in = frame_word[FRAME_BITS-1] ? PH_O_P : PH_Z_P1;
            timer_in = phase_len(phase_in, cfg);
         end
      end else begin
         if (cool_ff != '0) cool_in = cool_ff - TIMER_WIDTH'(1);
         if (phase_ff != PH_IDLE) begin
            if (timer_ff > TIMER_WIDTH'(1)) begin
               timer_in = timer_ff - TIMER_WIDTH'(1);
            end else begin
               case (phase_ff)
                  PH_Z_P1: phase_in = PH_Z_G1;
                  PH_Z_G1: phase_in = PH_Z_P2;
                  PH_Z_P2: phase_in = PH_Z_G2;
                  PH_O_P:  phase_in = PH_O_G;
                  PH_Z_G2, PH_O_G: begin
                     // End of a bit: shift and either stop or start the next
                     shift_in = next_shift;
                     bits_in  = bits_dec;
                     if (bits_dec == '0) begin
                        phase_in = PH_IDLE;
                        done     = 1'b1;
                     end else begin
                        phase_in = next_shift[FRAME_BITS-1] ? PH_O_P : PH_Z_P1;
                     end
                  end
                  default: phase_in = PH_IDLE;
               endcase
               timer_in = phase_len(phase_in, cfg);
            end
         end
      end
   end

   // Result seen after this request
   always_comb begin
      res.trigger_level  = (phase_in == PH_Z_P1) || (phase_in == PH_Z_P2)
                        || (phase_in == PH_O_P);
      res.busy_res       = (phase_in != PH_IDLE);
      res.request_status = status;
      res.frame_done     = done;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         shift_ff <= '0;
         bits_ff  <= '0;
         timer_ff <= '0;
         cool_ff  <= '0;
      end else if (acc) begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         bits_ff  <= bits_in;
         timer_ff <= timer_in;
         cool_ff  <= cool_in;
      end
   end

   // A request with sequencer idle and cooldown over starts a frame
   a_start: assert property (@(posedge clock) disable iff (reset)
      acc && func == FUNC_SEND && phase_ff == PH_IDLE && cool_ff == '0
      |=> phase_ff != PH_IDLE && bits_ff == BL_W'(FRAME_BITS))
      else $error("accepted send did not start a frame");

   // Bit counter runs exactly while a frame is on the line
   a_bits: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) == (bits_ff == '0))
      else $error("bit counter out of step with phase");

   // An active phase always has time left
   a_timer: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> timer_ff != '0)
      else $error("phase timer empty during a phase");

endmodule

`default_nettype wire

>>> sv/pcpt_out_reg.sv
// Result register between the sequencer and the response channel.
`default_nettype none

module pcpt_out_reg (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  load,
   input  pcpt_pkg::result_type res,
   output logic                 room,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tlast
);
   import pcpt_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   // Free when empty or being drained this cycle
   assign room       = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0000, data_ff.request_status, data_ff.busy_res,
                        data_ff.trigger_level};
   assign rsp_tlast  = data_ff.frame_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= res;
   end

   // Never overwrite a result that is still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_tready |-> !load)
      else $error("result overwritten before it was taken");

   // A loaded result is presented next cycle
   a_present: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_tvalid)
      else $error("loaded result not presented");

   // A result leaves only when taken or replaced
   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_tready |=> valid_ff)
      else $error("pending result dropped");

endmodule

`default_nettype wire

>>> sv/pulse_coded_packet_transmitter_core.sv
// Top level of the pulse coded packet transmitter.
//
//  channel | dir | handshake               | payload
//  req     | in  | req_tvalid / req_tready | tdata code+intensity, tuser func
//  rsp     | out | rsp_tvalid / rsp_tready | tdata trigger,busy,status; tlast done
//  csr     | in  | csr_valid / csr_ready   | csr_index, csr_wdata
//
// One request per clock while req_tready is high; its result appears next cycle.
// The sequencer state and the result register are the only pipeline stages.
// Reset (synchronous, active high) loads the register defaults and idles the line.
// req_tready drops only while a result sits unclaimed and rsp_tready is low.
// csr_ready is always high.
`default_nettype none

module pulse_coded_packet_transmitter_core #(
   parameter int FRAME_BITS  = pcpt_pkg::FRAME_BITS_DEF,
   parameter int TIMER_WIDTH = pcpt_pkg::TIMER_WIDTH_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire  [7:0]                 req_tdata,  // [2:0] sym_code, [4:3] intensity
   input  wire                        req_tuser,  // [0] func
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic [7:0]                 rsp_tdata,  // [0] trigger_level, [1] busy_res,
                                                  // [3:2] request_status
   output logic                       rsp_tlast,  // frame_done
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire  [pcpt_pkg::IDX_W-1:0] csr_index,
   input  wire  [pcpt_pkg::REG_W-1:0] csr_wdata
);
   import pcpt_pkg::*;

   cfg_type    cfg;
   result_type res;
   logic       room;
   logic       acc;

   assign req_tready = room;
   assign acc        = req_tvalid & req_tready;

   pcpt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pcpt_engine #(
      .FRAME_BITS  (FRAME_BITS),
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .acc          (acc),
      .func         (req_tuser),
      .sym_code     (req_tdata[2:0]),
      .intensity    (req_tdata[4:3]),
      .cfg          (cfg),
      .res          (res)
   );

   pcpt_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (acc),
      .res        (res),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
